### rtl/core/rgmg_pkg.sv
// package for the rotation gate matrix generator
// widths, cordic arctangent constants and gate kind codes; no dependencies
package rgmg_pkg;

	localparam int ANGLE_BITS   = 16;
	localparam int FRAC_BITS    = 14;
	localparam int OUT_W        = 16;
	localparam int CORDIC_ITERS = 30;
	localparam int IDX_W        = $clog2(CORDIC_ITERS);
	localparam int XY_W         = 34;
	localparam int Z_W          = 34;
	localparam int TRIG_W       = 32;
	localparam int PROD_W       = 2 * TRIG_W;
	localparam int LANES        = 4;
	localparam int SH_SINGLE    = 30 - FRAC_BITS;
	localparam int SH_PROD      = 60 - FRAC_BITS;
	localparam logic signed [XY_W-1:0] CORDIC_GAIN = XY_W'(652032874);
	localparam logic signed [TRIG_W-1:0] ONE_Q30 = TRIG_W'(64'sd1 <<< 30);

	typedef enum logic [1:0] {
		KIND_U  = 2'd0,
		KIND_RX = 2'd1,
		KIND_RY = 2'd2,
		KIND_RZ = 2'd3
	} kind_t;

	typedef struct packed {
		logic                   vld;
		kind_t                  kind;
		logic [LANES-1:0][1:0]  quad;
	} side_t;

	// arctangent of 2^-i as a 32-bit binary angle
	function automatic logic [31:0] atan_val(input logic [IDX_W-1:0] i);
		logic [31:0] v;
		case (i)
			5'd0:  v = 32'd536870912;
			5'd1:  v = 32'd316933406;
			5'd2:  v = 32'd167458907;
			5'd3:  v = 32'd85004756;
			5'd4:  v = 32'd42667331;
			5'd5:  v = 32'd21354465;
			5'd6:  v = 32'd10679838;
			5'd7:  v = 32'd5340245;
			5'd8:  v = 32'd2670163;
			5'd9:  v = 32'd1335087;
			5'd10: v = 32'd667544;
			5'd11: v = 32'd333772;
			5'd12: v = 32'd166886;
			5'd13: v = 32'd83443;
			5'd14: v = 32'd41722;
			5'd15: v = 32'd20861;
			5'd16: v = 32'd10430;
			5'd17: v = 32'd5215;
			5'd18: v = 32'd2608;
			5'd19: v = 32'd1304;
			5'd20: v = 32'd652;
			5'd21: v = 32'd326;
			5'd22: v = 32'd163;
			5'd23: v = 32'd81;
			5'd24: v = 32'd41;
			5'd25: v = 32'd20;
			5'd26: v = 32'd10;
			5'd27: v = 32'd5;
			5'd28: v = 32'd3;
			5'd29: v = 32'd1;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

endpackage

### rtl/core/rgmg_cordic_cell.sv
// one rotation-mode cordic iteration with its output register
// depends on rgmg_pkg
module rgmg_cordic_cell (
	input  logic                                clk,
	input  logic                                en,
	input  logic [rgmg_pkg::IDX_W-1:0]          idx,
	input  logic signed [rgmg_pkg::XY_W-1:0]    x_in,
	input  logic signed [rgmg_pkg::XY_W-1:0]    y_in,
	input  logic signed [rgmg_pkg::Z_W-1:0]     z_in,
	output logic signed [rgmg_pkg::XY_W-1:0]    x_out,
	output logic signed [rgmg_pkg::XY_W-1:0]    y_out,
	output logic signed [rgmg_pkg::Z_W-1:0]     z_out
);
	logic signed [rgmg_pkg::XY_W-1:0] x_q, y_q, xs, ys;
	logic signed [rgmg_pkg::Z_W-1:0]  z_q, at;

	assign xs = x_in >>> idx;
	assign ys = y_in >>> idx;
	assign at = rgmg_pkg::Z_W'(rgmg_pkg::atan_val(idx));

	always_ff @(posedge clk) begin
		if (en) begin
			if (!z_in[rgmg_pkg::Z_W-1]) begin
				x_q <= x_in - ys;
				y_q <= y_in + xs;
				z_q <= z_in - at;
			end else begin
				x_q <= x_in + ys;
				y_q <= y_in - xs;
				z_q <= z_in + at;
			end
		end
	end

	assign x_out = x_q;
	assign y_out = y_q;
	assign z_out = z_q;
endmodule

### rtl/core/rotation_gate_matrix_generator_unit.sv
// top level of the rotation gate matrix generator: four cordic cell chains,
// a product stage and rounding; depends on rgmg_pkg and rgmg_cordic_cell
//
// usage: one gate request per input beat on s_axis (kind, theta, phi, lam),
// one matrix per output beat on m_axis (eight q2.14 numbers, re/im of
// m00, m01, m10, m11). angles are binary angles, full scale is 2 pi.
// four chains of 30 cordic cells work in parallel on theta/2, phi, lam and
// phi+lam; then come a clamp and quadrant stage, a multiply stage and a
// round/saturate stage into the output register.
// throughput: one beat per cycle while the output is not stalled, set by the
// cell chains, which take a new angle set every cycle unless the pipeline holds.
// reset clears the valid marks of all stages; no output beat appears until
// requests are accepted. when the receiver stalls with a beat waiting, the
// whole pipeline holds and s_axis_tready drops; it rises again in the cycle
// the waiting beat is taken.
module rotation_gate_matrix_generator_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// kind[1:0], theta[17:2], phi[33:18], lam[49:34], zero pad to 56
	input  logic [55:0]  s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// m00_re, m00_im, m01_re, m01_im, m10_re, m10_im, m11_re, m11_im, 16 bits each
	output logic [127:0] m_axis_tdata
);
	localparam int N  = rgmg_pkg::CORDIC_ITERS;
	localparam int L  = rgmg_pkg::LANES;
	localparam int AB = rgmg_pkg::ANGLE_BITS;
	localparam int PROD_W = rgmg_pkg::PROD_W;

	logic en;
	logic out_vld_q;
	logic [127:0] out_q;
	logic [127:0] out_d;

	logic [AB-1:0] theta, phi, lam;
	logic [31:0] ang [L];

	rgmg_pkg::side_t side_q [0:N];
	rgmg_pkg::side_t side_s1, side_s2;

	logic signed [rgmg_pkg::XY_W-1:0] x_w [L][0:N];
	logic signed [rgmg_pkg::XY_W-1:0] y_w [L][0:N];
	logic signed [rgmg_pkg::Z_W-1:0]  z_w [L][0:N];
	logic signed [rgmg_pkg::Z_W-1:0]  z0_q [L];

	logic signed [rgmg_pkg::TRIG_W-1:0] co_s1 [L];
	logic signed [rgmg_pkg::TRIG_W-1:0] si_s1 [L];
	logic signed [rgmg_pkg::TRIG_W-1:0] ch_s2, sh_s2;
	logic signed [rgmg_pkg::PROD_W-1:0] p_s2 [6];

	assign en            = !out_vld_q || m_axis_tready;
	assign s_axis_tready = en;

	assign theta = s_axis_tdata[2 +: AB];
	assign phi   = s_axis_tdata[18 +: AB];
	assign lam   = s_axis_tdata[34 +: AB];

	always_comb begin
		ang[0] = (32'(theta) << (32 - AB)) >> 1;
		ang[1] = 32'(phi) << (32 - AB);
		ang[2] = 32'(lam) << (32 - AB);
		ang[3] = ang[1] + ang[2];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < L; l++) begin
				z0_q[l] <= rgmg_pkg::Z_W'($signed(ang[l]
					- {2'((ang[l] + 32'h2000_0000) >> 30), 30'b0}));
			end
		end
	end

	for (genvar l = 0; l < L; l++) begin : g_lane
		assign x_w[l][0] = rgmg_pkg::CORDIC_GAIN;
		assign y_w[l][0] = '0;
		assign z_w[l][0] = z0_q[l];
		for (genvar i = 0; i < N; i++) begin : g_cell
			rgmg_cordic_cell u_cell (
				.clk   (clk),
				.en    (en),
				.idx   (rgmg_pkg::IDX_W'(i)),
				.x_in  (x_w[l][i]),
				.y_in  (y_w[l][i]),
				.z_in  (z_w[l][i]),
				.x_out (x_w[l][i+1]),
				.y_out (y_w[l][i+1]),
				.z_out (z_w[l][i+1])
			);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= N; i++) side_q[i] <= '0;
			side_s1   <= '0;
			side_s2   <= '0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			// input stage: quadrant split
			side_q[0].vld  <= s_axis_tvalid;
			side_q[0].kind <= rgmg_pkg::kind_t'(s_axis_tdata[1:0]);
			for (int l = 0; l < L; l++) begin
				side_q[0].quad[l] <= 2'((ang[l] + 32'h2000_0000) >> 30);
			end
			for (int i = 1; i <= N; i++) side_q[i] <= side_q[i-1];
			side_s1   <= side_q[N];
			side_s2   <= side_s1;
			out_vld_q <= side_s2.vld;
		end
	end

	function automatic logic signed [rgmg_pkg::TRIG_W-1:0] clamp(
		input logic signed [rgmg_pkg::XY_W-1:0] v);
		logic signed [rgmg_pkg::XY_W-1:0] lim;
		lim = rgmg_pkg::XY_W'(rgmg_pkg::ONE_Q30);
		if (v > lim) return rgmg_pkg::ONE_Q30;
		if (v < -lim) return -rgmg_pkg::ONE_Q30;
		return rgmg_pkg::TRIG_W'(v);
	endfunction

	// clamp and quadrant rotation
	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < L; l++) begin
				case (side_q[N].quad[l])
					2'd0: begin
						co_s1[l] <= clamp(x_w[l][N]);
						si_s1[l] <= clamp(y_w[l][N]);
					end
					2'd1: begin
						co_s1[l] <= -clamp(y_w[l][N]);
						si_s1[l] <= clamp(x_w[l][N]);
					end
					2'd2: begin
						co_s1[l] <= -clamp(x_w[l][N]);
						si_s1[l] <= -clamp(y_w[l][N]);
					end
					default: begin
						co_s1[l] <= clamp(y_w[l][N]);
						si_s1[l] <= -clamp(x_w[l][N]);
					end
				endcase
			end
		end
	end

	// products for the u gate, lanes: 0 half theta, 1 phi, 2 lam, 3 phi+lam
	always_ff @(posedge clk) begin
		if (en) begin
			ch_s2   <= co_s1[0];
			sh_s2   <= si_s1[0];
			p_s2[0] <= PROD_W'(co_s1[2]) * PROD_W'(si_s1[0]);
			p_s2[1] <= PROD_W'(si_s1[2]) * PROD_W'(si_s1[0]);
			p_s2[2] <= PROD_W'(co_s1[1]) * PROD_W'(si_s1[0]);
			p_s2[3] <= PROD_W'(si_s1[1]) * PROD_W'(si_s1[0]);
			p_s2[4] <= PROD_W'(co_s1[3]) * PROD_W'(co_s1[0]);
			p_s2[5] <= PROD_W'(si_s1[3]) * PROD_W'(co_s1[0]);
		end
	end

	// round to nearest, ties up, then saturate to +-1.0
	function automatic logic [rgmg_pkg::OUT_W-1:0] rnd(
		input logic signed [PROD_W-1:0] v, input int s);
		logic signed [PROD_W-1:0] r, lim;
		r   = (v + (PROD_W'(1) <<< (s - 1))) >>> s;
		lim = PROD_W'(1) <<< rgmg_pkg::FRAC_BITS;
		if (r > lim) r = lim;
		if (r < -lim) r = -lim;
		return rgmg_pkg::OUT_W'(r);
	endfunction

	logic signed [PROD_W-1:0] chw, shw;
	logic [rgmg_pkg::OUT_W-1:0] c_r, s_r, ns_r;
	assign chw  = PROD_W'(ch_s2);
	assign shw  = PROD_W'(sh_s2);
	assign c_r  = rnd(chw, rgmg_pkg::SH_SINGLE);
	assign s_r  = rnd(shw, rgmg_pkg::SH_SINGLE);
	assign ns_r = rnd(-shw, rgmg_pkg::SH_SINGLE);

	always_comb begin
		out_d          = '0;
		out_d[15:0]    = c_r;
		out_d[111:96]  = c_r;
		unique case (side_s2.kind)
			rgmg_pkg::KIND_U: begin
				out_d[47:32]   = rnd(-p_s2[0], rgmg_pkg::SH_PROD);
				out_d[63:48]   = rnd(-p_s2[1], rgmg_pkg::SH_PROD);
				out_d[79:64]   = rnd(p_s2[2], rgmg_pkg::SH_PROD);
				out_d[95:80]   = rnd(p_s2[3], rgmg_pkg::SH_PROD);
				out_d[111:96]  = rnd(p_s2[4], rgmg_pkg::SH_PROD);
				out_d[127:112] = rnd(p_s2[5], rgmg_pkg::SH_PROD);
			end
			rgmg_pkg::KIND_RX: begin
				out_d[63:48] = ns_r;
				out_d[95:80] = ns_r;
			end
			rgmg_pkg::KIND_RY: begin
				out_d[47:32] = ns_r;
				out_d[79:64] = s_r;
			end
			rgmg_pkg::KIND_RZ: begin
				out_d[31:16]   = ns_r;
				out_d[127:112] = s_r;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q <= out_d;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_q;
endmodule

### rtl/core/rgmg_checker.sv
// port-level checks for rotation_gate_matrix_generator_unit, bound to the top
// depends on the top level's ports only
module rgmg_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [127:0] m_axis_tdata
);
	// a stalled output beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output beat changed while stalled");

	// input side is open whenever the output register is free or drains
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
		else $error("input blocked without output stall");

	a_block: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
		else $error("input taken during output stall");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ($signed(m_axis_tdata[15:0]) <= 16'sd16384)
			&& ($signed(m_axis_tdata[15:0]) >= -16'sd16384))
		else $error("m00_re out of range");
endmodule

bind rotation_gate_matrix_generator_unit rgmg_checker u_rgmg_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

### sim/rotation_gate_matrix_generator_unit_test.sv
// testbench for rotation_gate_matrix_generator_unit: random and directed gate requests
// checked against a built-in cordic matrix predictor; depends on rgmg_pkg and the rtl
`timescale 1ns / 1ps

module rotation_gate_matrix_generator_unit_test;

	localparam int N_RANDOM = 1950;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	// kind[1:0], theta[17:2], phi[33:18], lam[49:34], zero pad to 56
	logic [55:0]  s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	// m00_re, m00_im, m01_re, m01_im, m10_re, m10_im, m11_re, m11_im
	logic [127:0] m_axis_tdata;

	logic [55:0]  pending_requests[$];
	logic [127:0] expected_matrices[$];
	int           beats_sent;
	int           mismatches;
	int           tx_idle;
	int           rx_idle;

	longint atan_lut[30] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
		41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
		10, 5, 3, 1
	};

	rotation_gate_matrix_generator_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// cos and sin in q30 of a 32-bit binary angle
	task automatic cordic_trig(input logic [31:0] a, output longint co, output longint si);
		logic [31:0] q;
		logic [31:0] ru;
		longint      x, y, z, xn, yn;
		q  = ((a + 32'h2000_0000) >> 30) & 32'd3;
		ru = a - (q << 30);
		z  = longint'($signed(ru));
		x  = 652032874;
		y  = 0;
		for (int i = 0; i < 30; i++) begin
			if (z >= 0) begin
				xn = x - (y >>> i);
				yn = y + (x >>> i);
				z -= atan_lut[i];
			end else begin
				xn = x + (y >>> i);
				yn = y - (x >>> i);
				z += atan_lut[i];
			end
			x = xn;
			y = yn;
		end
		if (x > (64'sd1 <<< 30)) x = 64'sd1 <<< 30;
		if (x < -(64'sd1 <<< 30)) x = -(64'sd1 <<< 30);
		if (y > (64'sd1 <<< 30)) y = 64'sd1 <<< 30;
		if (y < -(64'sd1 <<< 30)) y = -(64'sd1 <<< 30);
		case (q[1:0])
			2'd0: begin co = x;  si = y;  end
			2'd1: begin co = -y; si = x;  end
			2'd2: begin co = -x; si = -y; end
			default: begin co = y; si = -x; end
		endcase
	endtask

	function automatic logic [15:0] round_sat(input longint v, input int s);
		longint r;
		longint lim;
		lim = 64'sd1 <<< rgmg_pkg::FRAC_BITS;
		r = (v + (64'sd1 <<< (s - 1))) >>> s;
		if (r > lim) r = lim;
		if (r < -lim) r = -lim;
		return r[15:0];
	endfunction

	function automatic logic [15:0] q30_out(input longint v);
		return round_sat(v, 30 - rgmg_pkg::FRAC_BITS);
	endfunction

	function automatic logic [15:0] q60_out(input longint a, input longint b, input bit neg);
		longint p;
		p = a * b;
		if (neg) p = -p;
		return round_sat(p, 60 - rgmg_pkg::FRAC_BITS);
	endfunction

	task automatic predict_matrix(input logic [55:0] req, output logic [127:0] m);
		rgmg_pkg::kind_t kind;
		logic [31:0] th, ph, la;
		longint      ch, sh, cp, sp, cl, sl, cs, ss;
		logic [15:0] f[8];
		kind = rgmg_pkg::kind_t'(req[1:0]);
		th = {req[17:2], 16'h0};
		ph = {req[33:18], 16'h0};
		la = {req[49:34], 16'h0};
		foreach (f[k]) f[k] = '0;
		cordic_trig(th >> 1, ch, sh);
		f[0] = q30_out(ch);
		f[6] = q30_out(ch);
		case (kind)
			rgmg_pkg::KIND_U: begin
				cordic_trig(ph, cp, sp);
				cordic_trig(la, cl, sl);
				cordic_trig(ph + la, cs, ss);
				f[2] = q60_out(cl, sh, 1'b1);
				f[3] = q60_out(sl, sh, 1'b1);
				f[4] = q60_out(cp, sh, 1'b0);
				f[5] = q60_out(sp, sh, 1'b0);
				f[6] = q60_out(cs, ch, 1'b0);
				f[7] = q60_out(ss, ch, 1'b0);
			end
			rgmg_pkg::KIND_RX: begin
				f[3] = q30_out(-sh);
				f[5] = q30_out(-sh);
			end
			rgmg_pkg::KIND_RY: begin
				f[2] = q30_out(-sh);
				f[4] = q30_out(sh);
			end
			default: begin
				f[1] = q30_out(-sh);
				f[7] = q30_out(sh);
			end
		endcase
		for (int k = 0; k < 8; k++) m[16*k +: 16] = f[k];
	endtask

	function automatic logic [55:0] gate_request(input rgmg_pkg::kind_t kind,
			input logic [15:0] theta, input logic [15:0] phi, input logic [15:0] lam);
		return {6'b0, lam, phi, theta, kind};
	endfunction

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// idling profile follows progress through the stimulus
	always_comb begin
		if (beats_sent < 660) begin
			tx_idle = 12;
			rx_idle = 59;
		end else if (beats_sent < 1320) begin
			tx_idle = 59;
			rx_idle = 12;
		end else begin
			tx_idle = 0;
			rx_idle = 0;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			beats_sent    <= 0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (s_axis_tvalid) beats_sent <= beats_sent + 1;
			if (pending_requests.size() > 0 && $urandom_range(99) >= tx_idle) begin
				s_axis_tdata  <= pending_requests.pop_front();
				s_axis_tvalid <= 1'b1;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_axis_tready <= 1'b0;
		else m_axis_tready <= ($urandom_range(99) >= rx_idle);
	end

	always @(posedge clk) begin
		logic [127:0] want;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				predict_matrix(s_axis_tdata, want);
				expected_matrices.push_back(want);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_matrices.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected output beat %h", m_axis_tdata);
				end else begin
					want = expected_matrices.pop_front();
					for (int k = 0; k < 8; k++) begin
						if (m_axis_tdata[16*k +: 16] !== want[16*k +: 16]) begin
							mismatches++;
							if (mismatches <= 10)
								$display("field %0d: expected %h, got %h",
									k, want[16*k +: 16], m_axis_tdata[16*k +: 16]);
						end
					end
				end
			end
		end
	end

	initial begin
		logic [15:0] corner[6];
		corner = '{16'h0000, 16'hffff, 16'h4000, 16'h8000, 16'hc000, 16'h0001};
		mismatches = 0;
		arst_n = 1'b0;
		// directed corners: every kind over angle extremes, quarter turns
		for (int k = 0; k < 4; k++)
			foreach (corner[i])
				pending_requests.push_back(gate_request(rgmg_pkg::kind_t'(k), corner[i],
					corner[(i + 1) % 6], corner[(i + 3) % 6]));
		// unused angles must not matter for rotations
		pending_requests.push_back(gate_request(rgmg_pkg::KIND_RX, 16'h1234, 16'hffff,
			16'hffff));
		for (int n = 0; n < N_RANDOM; n++)
			pending_requests.push_back(gate_request(rgmg_pkg::kind_t'($urandom_range(3)),
				16'($urandom), 16'($urandom), 16'($urandom)));
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		while (pending_requests.size() > 0 || s_axis_tvalid) @(posedge clk);
		while (expected_matrices.size() > 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0 && expected_matrices.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#3_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
